// ===== src/plet_pkg.sv =====
// Shared types and constants for the priority/LRU eviction table.
package plet_pkg;

  localparam int EntriesDefault = 16;
  localparam int MaxEvictDefault = 16;
  localparam logic [3:0] PrioCeil = 4'd11;

  localparam int SizeW = 40;
  localparam int TotW = 44;
  localparam int TickW = 48;
  localparam int IdxW = 4;
  localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};

  typedef enum logic [1:0] {
    MODE_DEFINE = 2'd0,
    MODE_TOUCH  = 2'd1,
    MODE_LOAD   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_EVICT = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_ACK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RESIDENT = 2'd1,
    ST_FAIL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ES_UNDEF    = 2'd0,
    ES_IDLE     = 2'd1,
    ES_RESIDENT = 2'd2
  } ent_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_EVICT,
    S_FINISH,
    S_OUT
  } fsm_t;

  // Candidate flowing along the scan chain.
  typedef struct packed {
    logic              found;
    logic [IdxW-1:0]   idx;
    logic [3:0]        prio;
    logic [TickW-1:0]  tick;
  } cand_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic              define;
    logic              touch;
    logic              make_res;
    logic              evict;
    logic [IdxW-1:0]   idx;
    logic [SizeW-1:0]  size;
    logic [3:0]        prio;
    logic              strict;
    logic [TickW-1:0]  tick;
  } cell_cmd_t;

endpackage

// ===== src/plet_if.sv =====
// Valid/ready channel interfaces for input and result transactions.
interface plet_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  entry_index;
  logic [39:0] entry_size;
  logic [3:0]  entry_priority;
  logic        strict_flag;
  logic [47:0] access_tick;
  modport source (output valid, mode, entry_index, entry_size, entry_priority,
                  strict_flag, access_tick, input ready);
  modport sink (input valid, mode, entry_index, entry_size, entry_priority,
                strict_flag, access_tick, output ready);
endinterface

interface plet_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  result_index;
  logic [1:0]  status;
  logic [43:0] allocated_after;
  logic        last;
  modport source (output valid, result_kind, result_index, status, allocated_after,
                  last, input ready);
  modport sink (input valid, result_kind, result_index, status, allocated_after,
                last, output ready);
endinterface

// ===== src/priority_lru_eviction_table.sv =====
// Top level: priority-then-LRU eviction table with a chain of entry cells.
// Usage:
//   in_ch  carries define (0), touch (1) and load (2) transactions.
//   out_ch returns results; the last result of a transaction has last = 1.
//   capacity_limit_we/capacity_limit set the byte limit; write only when idle.
// Define, touch and loads that are not placed register their result from the
// check state, a load that is placed from the finish state; ready returns at
// the same edge. A load that needs room runs one scan per eviction: the victim
// candidate ripples through the cell chain one cell per cycle, and after the
// scan, evict and out states the final load result comes from the finish state.
// One transaction is in flight at a time; ready is high only while the
// sequencer is idle, so the next transaction is taken once it returns to idle.
// Reset clears all entry states to undefined, the total and the limit to 0.
// A stalled receiver holds the result register; the sequencer waits for it.
module priority_lru_eviction_table import plet_pkg::*; #(
  parameter int ENTRIES = EntriesDefault,
  parameter int MAX_EVICT = MaxEvictDefault
) (
  input  logic              clk,
  input  logic              rst,
  plet_in_if.sink           in_ch,
  plet_out_if.source        out_ch,
  input  logic              capacity_limit_we,
  input  logic [SizeW-1:0]  capacity_limit
);

  logic [SizeW-1:0]  limit;
  cell_cmd_t         cmd;
  cand_t             chain [ENTRIES+1];
  ent_state_t        st [ENTRIES];
  logic [SizeW-1:0]  sz [ENTRIES];
  logic [IdxW-1:0]   sel_idx;
  ent_state_t        sel_state;
  logic [SizeW-1:0]  sel_size;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) limit <= '0;
    else if (capacity_limit_we) limit <= capacity_limit;
  end

  assign chain[0] = '0;

  // Cell chain
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    plet_cell #(.IW(IdxW), .MyIdx(IdxW'(g))) u_cell (
      .clk, .rst, .cmd,
      .cand_in(chain[g]), .cand_out(chain[g+1]),
      .state(st[g]), .size(sz[g])
    );
  end

  // Entry select for status/size lookup
  always_comb begin
    sel_state = ES_UNDEF;
    sel_size  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel_idx == IdxW'(i)) begin
        sel_state = st[i];
        sel_size  = sz[i];
      end
    end
  end

  plet_ctrl #(.ENTRIES(ENTRIES), .MAX_EVICT(MAX_EVICT)) u_ctrl (
    .clk, .rst, .in_ch, .out_ch,
    .capacity_limit(limit), .cmd,
    .cand_last(chain[ENTRIES]),
    .sel_state, .sel_size, .sel_idx
  );

endmodule

// ===== src/plet_cell.sv =====
// One table entry: holds its fields and compares against the passing candidate.
module plet_cell import plet_pkg::*; #(
  parameter int IW = 4,
  parameter logic [IW-1:0] MyIdx = '0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_cmd_t               cmd,
  input  cand_t                   cand_in,
  output cand_t                   cand_out,
  output ent_state_t              state,
  output logic [SizeW-1:0]        size
);

  ent_state_t        st;
  logic [3:0]        prio;
  logic              strict;
  logic [TickW-1:0]  tick;
  logic              hit;
  logic              better;

  assign hit = (cmd.idx[IW-1:0] == MyIdx) && (cmd.idx >> IW) == '0;

  // Entry status
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ES_UNDEF;
    end else if (hit && cmd.define) begin
      st <= ES_IDLE;
    end else if (hit && cmd.make_res) begin
      st <= ES_RESIDENT;
    end else if (hit && cmd.evict) begin
      st <= ES_IDLE;
    end
  end

  // Payload fields
  always_ff @(posedge clk) begin
    if (hit && cmd.define) begin
      size   <= cmd.size;
      prio   <= cmd.prio;
      strict <= cmd.strict;
      tick   <= '0;
    end else if (hit && cmd.touch) begin
      tick <= cmd.tick;
    end
  end

  // Victim compare: lower prio wins, then older tick; earlier index keeps ties
  always_comb begin
    better = 1'b0;
    if (st == ES_RESIDENT && !strict && prio < PrioCeil) begin
      if (!cand_in.found) better = 1'b1;
      else if (prio < cand_in.prio) better = 1'b1;
      else if (prio == cand_in.prio && tick < cand_in.tick) better = 1'b1;
    end
  end

  // Candidate register toward the next cell
  always_ff @(posedge clk) begin
    if (better) begin
      cand_out.found <= 1'b1;
      cand_out.idx   <= IdxW'(MyIdx);
      cand_out.prio  <= prio;
      cand_out.tick  <= tick;
    end else begin
      cand_out <= cand_in;
    end
  end

  assign state = st;

endmodule

// ===== src/plet_ctrl.sv =====
// Sequencer: decodes transactions, runs eviction scans over the cell chain.
module plet_ctrl import plet_pkg::*; #(
  parameter int ENTRIES = EntriesDefault,
  parameter int MAX_EVICT = MaxEvictDefault
) (
  input  logic              clk,
  input  logic              rst,
  plet_in_if.sink           in_ch,
  plet_out_if.source        out_ch,
  input  logic [SizeW-1:0]  capacity_limit,
  output cell_cmd_t         cmd,
  input  cand_t             cand_last,
  input  ent_state_t        sel_state,
  input  logic [SizeW-1:0]  sel_size,
  output logic [IdxW-1:0]   sel_idx
);

  localparam int CntW = $clog2(ENTRIES + 1);
  localparam int EvW = $clog2(MAX_EVICT + 1);

  fsm_t               fsm, fsm_next;
  logic [1:0]         mode;
  logic [IdxW-1:0]    idx;
  logic [SizeW-1:0]   isize;
  logic [3:0]         iprio;
  logic               istrict;
  logic [TickW-1:0]   itick;
  logic [SizeW-1:0]   lsize;
  logic [SizeW-1:0]   nsize;
  logic [TotW-1:0]    total;
  logic [CntW-1:0]    cnt;
  logic [EvW-1:0]     ev;
  logic               fail;
  logic               over;
  logic [TotW:0]      need;
  logic               in_range;

  // Output register
  logic               ov;
  logic               ov_set;
  logic [1:0]         okind;
  logic [IdxW-1:0]    oidx;
  logic [1:0]         ost;
  logic               olast;

  logic               acc;
  logic               out_free;

  assign acc = in_ch.valid && in_ch.ready;
  assign out_free = !ov || out_ch.ready;
  assign in_ch.ready = (fsm == S_IDLE);
  assign in_range = (32'(idx) < ENTRIES);
  assign sel_idx = (fsm == S_EVICT) ? cand_last.idx : idx;
  // The load size is still in the table while the transaction is decoded
  assign nsize = (fsm == S_CHECK) ? sel_size : lsize;
  assign need = {1'b0, total} + (TotW+1)'(nsize);
  assign over = need > (TotW+1)'(capacity_limit);

  function automatic logic [TotW-1:0] sub_sat(logic [TotW-1:0] a, logic [SizeW-1:0] b);
    logic [TotW-1:0] bw;
    bw = TotW'(b);
    return (a >= bw) ? a - bw : '0;
  endfunction

  // Next state
  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      S_IDLE: if (acc) fsm_next = S_CHECK;
      S_CHECK: begin
        if (out_free) begin
          if (mode == MODE_NONE) fsm_next = S_IDLE;
          else if (!in_range || mode != MODE_LOAD || sel_state != ES_IDLE) fsm_next = S_IDLE;
          else if (!over || sel_size > capacity_limit) fsm_next = S_FINISH;
          else fsm_next = S_SCAN;
        end
      end
      S_SCAN: if (32'(cnt) == ENTRIES) fsm_next = S_EVICT;
      S_EVICT: begin
        if (!cand_last.found) fsm_next = S_FINISH;
        else if (out_free) fsm_next = S_OUT;
      end
      S_OUT: begin
        if (!over) fsm_next = S_FINISH;
        else if (32'(ev) >= MAX_EVICT) fsm_next = S_FINISH;
        else fsm_next = S_SCAN;
      end
      S_FINISH: if (out_free) fsm_next = S_IDLE;
      default: fsm_next = S_IDLE;
    endcase
  end

  // Cell command
  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    cmd.size = isize;
    cmd.prio = iprio;
    cmd.strict = istrict;
    cmd.tick = itick;
    unique case (fsm)
      S_CHECK: if (out_free && in_range) begin
        cmd.define = (mode == MODE_DEFINE);
        cmd.touch = (mode == MODE_TOUCH) && sel_state != ES_UNDEF;
      end
      S_EVICT: if (cand_last.found && out_free) begin
        cmd.evict = 1'b1;
        cmd.idx = cand_last.idx;
      end
      S_FINISH: if (out_free) cmd.make_res = 1'b1;
      default: ;
    endcase
  end

  // A new result enters the output register
  always_comb begin
    ov_set = 1'b0;
    unique case (fsm)
      S_CHECK: ov_set = out_free && mode != MODE_NONE &&
                        (!in_range || mode != MODE_LOAD || sel_state != ES_IDLE);
      S_EVICT: ov_set = cand_last.found && out_free;
      S_FINISH: ov_set = out_free;
      default: ;
    endcase
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ov_set) begin
      ov <= 1'b1;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm   <= S_IDLE;
      total <= '0;
      ev    <= '0;
    end else begin
      fsm <= fsm_next;
      unique case (fsm)
        S_CHECK: if (out_free) begin
          fail  <= over && sel_size > capacity_limit;
          ev    <= '0;
          lsize <= sel_size;
          okind <= (mode == MODE_LOAD) ? KIND_LOAD : KIND_ACK;
          oidx  <= idx;
          olast <= 1'b1;
          if (!in_range) begin
            ost <= ST_FAIL;
          end else if (mode == MODE_DEFINE) begin
            ost <= ST_OK;
            if (sel_state == ES_RESIDENT) total <= sub_sat(total, sel_size);
          end else if (mode == MODE_TOUCH) begin
            ost <= (sel_state == ES_UNDEF) ? ST_FAIL : ST_OK;
          end else if (sel_state == ES_UNDEF) begin
            ost <= ST_FAIL;
          end else if (sel_state == ES_RESIDENT) begin
            ost <= ST_RESIDENT;
          end
        end
        S_SCAN: cnt <= cnt + 1'b1;
        S_EVICT: begin
          if (!cand_last.found) fail <= 1'b1;
          else if (out_free) begin
            okind <= KIND_EVICT;
            oidx  <= cand_last.idx;
            ost   <= ST_OK;
            olast <= 1'b0;
            ev    <= ev + 1'b1;
            total <= sub_sat(total, sel_size);
          end
        end
        S_OUT: begin
          cnt <= '0;
          if (over && 32'(ev) >= MAX_EVICT) fail <= 1'b1;
        end
        S_FINISH: if (out_free) begin
          total <= need[TotW] ? TotMax : need[TotW-1:0];
          okind <= KIND_LOAD;
          oidx  <= idx;
          ost   <= fail ? ST_FAIL : ST_OK;
          olast <= 1'b1;
        end
        default: ;
      endcase
      if (fsm == S_CHECK) cnt <= '0;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (acc) begin
      mode    <= in_ch.mode;
      idx     <= in_ch.entry_index;
      isize   <= in_ch.entry_size;
      iprio   <= in_ch.entry_priority;
      istrict <= in_ch.strict_flag;
      itick   <= in_ch.access_tick;
    end
  end

  assign out_ch.valid = ov;
  assign out_ch.result_kind = okind;
  assign out_ch.result_index = oidx;
  assign out_ch.status = ost;
  assign out_ch.allocated_after = total;
  assign out_ch.last = olast;

  // Checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> fsm == S_IDLE) else $error("ready outside idle");
  a_evict_found: assert property (@(posedge clk) disable iff (rst)
    cmd.evict |-> cand_last.found) else $error("evict without victim");
  a_ev_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ev) <= MAX_EVICT) else $error("eviction bound exceeded");

endmodule
